// ===== rtl/rrwl_pkg.sv =====
// Shared types and constants for the record reader/writer lock table.
// Used by rrwl_cell, rrwl_ctrl and record_reader_writer_lock_table.
package rrwl_pkg;

	localparam int HOLDERS = 64;

	// request modes
	localparam logic [1:0] MODE_READ    = 2'd0;
	localparam logic [1:0] MODE_WRITE   = 2'd1;
	localparam logic [1:0] MODE_RELEASE = 2'd2;

	// result status codes
	localparam logic [2:0] ST_GRANTED  = 3'd0;
	localparam logic [2:0] ST_CONFLICT = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_RELEASED = 3'd3;
	localparam logic [2:0] ST_NOTHING  = 3'd4;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] record_id;
		logic [7:0]  client_id;
	} req_t;

	typedef struct packed {
		logic       granted;
		logic [2:0] status;
	} rsp_t;

	// request token that walks the cell chain, gathering scan results
	typedef struct packed {
		logic vld;
		req_t req;
		logic conflict;
		logic free_found;
		logic removed;
	} tok_t;

	// end-of-scan broadcast from the controller to all cells
	typedef struct packed {
		logic done;
		logic commit;
	} fin_t;

endpackage

// ===== rtl/rrwl_cell.sv =====
// One holder entry of the lock table and its stage of the request chain.
// Depends on rrwl_pkg for the token and broadcast types.
module rrwl_cell import rrwl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  tok_t tok_in,
	input  fin_t fin,
	output tok_t tok_out
);

	logic        valid_q;
	logic        tent_q;
	logic [15:0] rec_q;
	logic [7:0]  cli_q;
	logic        wr_q;
	tok_t        tok_q;

	logic is_acq;
	logic wr_req;
	logic hit_rec;
	logic hit_cli;
	logic claim;
	logic drop;
	tok_t tok_nxt;

	// decode the passing request against this entry
	always_comb begin
		is_acq  = (tok_in.req.mode == MODE_READ) || (tok_in.req.mode == MODE_WRITE);
		wr_req  = (tok_in.req.mode == MODE_WRITE);
		hit_rec = valid_q && (rec_q == tok_in.req.record_id);
		hit_cli = hit_rec && (cli_q == tok_in.req.client_id);
		claim   = tok_in.vld && is_acq && !valid_q && !tok_in.free_found;
		drop    = tok_in.vld && (tok_in.req.mode == MODE_RELEASE) && hit_cli;
		tok_nxt            = tok_in;
		tok_nxt.conflict   = tok_in.conflict || (hit_rec && (wr_req || wr_q));
		tok_nxt.free_found = tok_in.free_found || !valid_q;
		tok_nxt.removed    = tok_in.removed || hit_cli;
	end

	// hold entry state: reserve on claim, commit or cancel at end of scan, drop on release;
	// advance the token one cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tent_q  <= 1'b0;
			tok_q   <= '0;
		end else begin
			tok_q <= tok_nxt;
			if (fin.done) begin
				if (tent_q && fin.commit) begin
					valid_q <= 1'b1;
				end
				tent_q <= 1'b0;
			end else if (claim) begin
				tent_q <= 1'b1;
			end else if (drop) begin
				valid_q <= 1'b0;
			end
		end
	end

	// latch entry payload on claim
	always_ff @(posedge clk) begin
		if (claim) begin
			rec_q <= tok_in.req.record_id;
			cli_q <= tok_in.req.client_id;
			wr_q  <= wr_req;
		end
	end

	assign tok_out = tok_q;

endmodule

// ===== rtl/rrwl_ctrl.sv =====
// Request intake, end-of-scan decision and result buffering for the lock table.
// Depends on rrwl_pkg for request, result, token and broadcast types.
module rrwl_ctrl import rrwl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp,
	output tok_t tok_head,
	input  tok_t tok_tail,
	output fin_t fin
);

	logic busy_q;
	logic out_vld_q;
	logic skid_vld_q;
	rsp_t out_q;
	rsp_t skid_q;
	tok_t inj_q;
	rsp_t res;
	logic is_acq;
	logic accept;
	logic finish;
	logic take;

	assign req_ready = !busy_q && !skid_vld_q;
	assign accept    = req_valid && req_ready;
	assign finish    = tok_tail.vld;
	assign take      = out_vld_q && rsp_ready;

	// decide the result once the token leaves the last cell
	always_comb begin
		is_acq     = (tok_tail.req.mode == MODE_READ) || (tok_tail.req.mode == MODE_WRITE);
		fin.done   = finish;
		fin.commit = is_acq && !tok_tail.conflict && tok_tail.free_found;
		case (tok_tail.req.mode)
			MODE_READ, MODE_WRITE: begin
				if (tok_tail.conflict) begin
					res = '{granted: 1'b0, status: ST_CONFLICT};
				end else if (!tok_tail.free_found) begin
					res = '{granted: 1'b0, status: ST_FULL};
				end else begin
					res = '{granted: 1'b1, status: ST_GRANTED};
				end
			end
			MODE_RELEASE: begin
				if (tok_tail.removed) begin
					res = '{granted: 1'b1, status: ST_RELEASED};
				end else begin
					res = '{granted: 1'b0, status: ST_NOTHING};
				end
			end
			default: res = '{granted: 1'b0, status: ST_CONFLICT};
		endcase
	end

	// track the transaction in flight and the two result slots; load the injection token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
			inj_q      <= '0;
		end else begin
			inj_q <= '{vld: accept, req: req, conflict: 1'b0, free_found: 1'b0,
				removed: 1'b0};
			if (accept) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			if (!out_vld_q || take) begin
				out_vld_q  <= skid_vld_q || finish;
				skid_vld_q <= 1'b0;
			end else if (finish) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	// load result payloads
	always_ff @(posedge clk) begin
		if (!out_vld_q || take) begin
			out_q <= skid_vld_q ? skid_q : res;
		end else if (finish) begin
			skid_q <= res;
		end
	end

	assign tok_head  = inj_q;
	assign rsp_valid = out_vld_q;
	assign rsp       = out_q;

endmodule

// ===== rtl/record_reader_writer_lock_table.sv =====
// Record reader/writer lock table: a row of HOLDERS holder cells scanned by a request token.
// One token walks one cell per cycle, so one request is in the chain at a time: a new
// request is taken only once the last token has left the chain and the skid slot is empty;
// a finished result waits in an output register or skid slot while the next request is taken.
// Reset: arst_n clears all holder entries to invalid at once; no clearing pass.
module record_reader_writer_lock_table import rrwl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	tok_t chain [HOLDERS+1];
	fin_t fin;

	// accept requests, inject tokens, decide and buffer results
	rrwl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.tok_head  (chain[0]),
		.tok_tail  (chain[HOLDERS]),
		.fin       (fin)
	);

	// chain the holder cells
	for (genvar i = 0; i < HOLDERS; i++) begin : g_cell
		rrwl_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (chain[i]),
			.fin     (fin),
			.tok_out (chain[i+1])
		);
	end

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for record_reader_writer_lock_table.
// Depends on rrwl_pkg for the request/result structs, mode and status codes and HOLDERS;
// predicts every result with its own holder table and compares it field by field.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rrwl_pkg::*;

	// the one request code the package leaves unnamed
	localparam logic [1:0] MODE_UNDEFINED = 2'd3;
	localparam int REC_POOL = 8;
	localparam int CLI_POOL = 4;
	localparam int SCAN_CYCLES = HOLDERS + 2;

	typedef struct {
		logic        held;
		logic [15:0] rec;
		logic [7:0]  cli;
		logic        exclusive;
	} lock_entry_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	lock_entry_t lock_table [HOLDERS];
	rsp_t pending_outcomes [$];
	logic [15:0] rec_pool [REC_POOL];
	logic [7:0] cli_pool [CLI_POOL];
	int send_idle_pct = 9;
	int drain_idle_pct = 9;
	int hold_left = 0;
	int errors = 0;

	record_reader_writer_lock_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// hard stop well beyond the slowest correct run
	initial begin
		#8_000_000;
		$display("tb: FAIL");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= 40) begin
			$display("tb: mismatch: %s", msg);
		end
	endtask

	// apply one request to the holder table and return its outcome
	function automatic rsp_t lock_outcome(input req_t r);
		rsp_t o;
		logic clash;
		logic hit;
		int slot;
		int i;
		o.granted = 1'b0;
		o.status = ST_CONFLICT;
		clash = 1'b0;
		hit = 1'b0;
		slot = -1;
		case (r.mode)
			MODE_READ, MODE_WRITE: begin
				for (i = 0; i < HOLDERS; i++) begin
					if (lock_table[i].held && lock_table[i].rec == r.record_id &&
					    (r.mode == MODE_WRITE || lock_table[i].exclusive)) begin
						clash = 1'b1;
					end
				end
				// lowest free slot wins
				for (i = HOLDERS - 1; i >= 0; i--) begin
					if (!lock_table[i].held) begin
						slot = i;
					end
				end
				if (clash) begin
					o.status = ST_CONFLICT;
				end else if (slot < 0) begin
					o.status = ST_FULL;
				end else begin
					lock_table[slot].held = 1'b1;
					lock_table[slot].rec = r.record_id;
					lock_table[slot].cli = r.client_id;
					lock_table[slot].exclusive = (r.mode == MODE_WRITE);
					o.granted = 1'b1;
					o.status = ST_GRANTED;
				end
			end
			MODE_RELEASE: begin
				for (i = 0; i < HOLDERS; i++) begin
					if (lock_table[i].held && lock_table[i].rec == r.record_id &&
					    lock_table[i].cli == r.client_id) begin
						lock_table[i].held = 1'b0;
						hit = 1'b1;
					end
				end
				o.granted = hit;
				o.status = hit ? ST_RELEASED : ST_NOTHING;
			end
			default: begin
				o.status = ST_CONFLICT;
			end
		endcase
		return o;
	endfunction

	function automatic int held_count();
		int n;
		int i;
		n = 0;
		for (i = 0; i < HOLDERS; i++) begin
			if (lock_table[i].held) begin
				n++;
			end
		end
		return n;
	endfunction

	function automatic req_t make_req(input logic [1:0] m, input logic [15:0] r,
	                                  input logic [7:0] c);
		req_t q;
		q.mode = m;
		q.record_id = r;
		q.client_id = c;
		return q;
	endfunction

	// mostly pooled records and clients so that requests collide
	function automatic req_t random_request(input bit fill_phase);
		req_t r;
		int pick;
		int slot;
		int j;
		int i;
		pick = $urandom_range(99);
		slot = -1;
		r.mode = MODE_RELEASE;
		r.record_id = rec_pool[$urandom_range(REC_POOL - 1)];
		r.client_id = cli_pool[$urandom_range(CLI_POOL - 1)];
		if (pick < 5) begin
			r.mode = 2'($urandom_range(3));
			r.record_id = 16'($urandom_range(16'hFFFF));
			r.client_id = 8'($urandom_range(255));
		end else if (pick < (fill_phase ? 70 : 25)) begin
			r.mode = MODE_READ;
		end else if (pick < (fill_phase ? 82 : 37)) begin
			r.mode = MODE_WRITE;
		end else if ($urandom_range(1) == 1) begin
			// aim the release at an entry held right now
			for (i = 0; i < 8 && slot < 0; i++) begin
				j = $urandom_range(HOLDERS - 1);
				if (lock_table[j].held) begin
					slot = j;
				end
			end
			if (slot >= 0) begin
				r.record_id = lock_table[slot].rec;
				r.client_id = lock_table[slot].cli;
			end
		end
		return r;
	endfunction

	// offer one request; returns at the edge where it is taken, with valid still high,
	// so callers go straight on to the next request or to finish_run
	task automatic send_request(input req_t item);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (!req_ready) begin
			@(posedge clk);
		end
		pending_outcomes = {pending_outcomes, lock_outcome(item)};
	endtask

	// drive the result side: long hold-off first, else random stalls
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rsp_ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ready <= ($urandom_range(99) >= drain_idle_pct);
			end
		end
	end

	// compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_outcomes.size() == 0) begin
				report_mismatch($sformatf("result g=%0b s=%0d with nothing outstanding",
					rsp.granted, rsp.status));
			end else begin
				want = pending_outcomes.pop_front();
				if (rsp.granted !== want.granted) begin
					report_mismatch($sformatf("granted %b, predicted %b",
						rsp.granted, want.granted));
				end
				if (rsp.status !== want.status) begin
					report_mismatch($sformatf("status %0d, predicted %0d",
						rsp.status, want.status));
				end
			end
		end
	end

	// field extremes, every mode, duplicates, conflicts and empty releases
	task automatic test_directed();
		send_request(make_req(MODE_RELEASE, 16'h0000, 8'h00));
		send_request(make_req(MODE_READ, 16'h0000, 8'h00));
		send_request(make_req(MODE_READ, 16'h0000, 8'h00));
		send_request(make_req(MODE_READ, 16'h0000, 8'hFF));
		send_request(make_req(MODE_WRITE, 16'h0000, 8'h80));
		send_request(make_req(MODE_RELEASE, 16'h0000, 8'h00));
		send_request(make_req(MODE_RELEASE, 16'h0000, 8'h00));
		send_request(make_req(MODE_RELEASE, 16'h0000, 8'hFF));
		send_request(make_req(MODE_WRITE, 16'hFFFF, 8'hFF));
		send_request(make_req(MODE_READ, 16'hFFFF, 8'h00));
		send_request(make_req(MODE_WRITE, 16'hFFFF, 8'hFF));
		send_request(make_req(MODE_READ, 16'hFFFF, 8'hFF));
		send_request(make_req(MODE_RELEASE, 16'hFFFF, 8'h01));
		send_request(make_req(MODE_UNDEFINED, 16'hFFFF, 8'hFF));
		send_request(make_req(MODE_UNDEFINED, 16'h5A5A, 8'hA5));
		send_request(make_req(MODE_RELEASE, 16'hFFFF, 8'hFF));
		send_request(make_req(MODE_WRITE, 16'hFFFF, 8'h00));
		send_request(make_req(MODE_RELEASE, 16'hFFFF, 8'h00));
		send_request(make_req(MODE_READ, 16'h8000, 8'h7F));
		send_request(make_req(MODE_READ, 16'h7FFF, 8'h80));
		send_request(make_req(MODE_WRITE, 16'h0001, 8'h01));
		send_request(make_req(MODE_RELEASE, 16'h8000, 8'h7F));
		send_request(make_req(MODE_RELEASE, 16'h7FFF, 8'h80));
		send_request(make_req(MODE_RELEASE, 16'h0001, 8'h01));
	endtask

	// fill every slot, check full versus conflict, refill a freed slot, then drain
	task automatic test_table_full();
		int i;
		int slot;
		while (held_count() < HOLDERS) begin
			send_request(make_req(MODE_READ, 16'(16'h1000 + $urandom_range(15)),
				8'($urandom_range(255))));
		end
		send_request(make_req(MODE_READ, 16'h1003, 8'h42));
		send_request(make_req(MODE_WRITE, 16'(16'h1000 + $urandom_range(15)), 8'h42));
		send_request(make_req(MODE_WRITE, 16'h0F00, 8'h42));
		send_request(make_req(MODE_UNDEFINED, 16'h0F00, 8'h42));
		slot = $urandom_range(HOLDERS - 1);
		send_request(make_req(MODE_RELEASE, lock_table[slot].rec, lock_table[slot].cli));
		while (held_count() < HOLDERS) begin
			send_request(make_req(MODE_READ, 16'h1007, 8'($urandom_range(255))));
		end
		send_request(make_req(MODE_READ, 16'h2000, 8'h00));
		// drain by releasing whatever the lowest held slot holds
		while (held_count() > 0) begin
			slot = -1;
			for (i = HOLDERS - 1; i >= 0; i--) begin
				if (lock_table[i].held) begin
					slot = i;
				end
			end
			send_request(make_req(MODE_RELEASE, lock_table[slot].rec, lock_table[slot].cli));
		end
	endtask

	// alternate acquire-heavy and release-heavy phases over fresh pools
	task automatic test_random_traffic();
		int phase;
		int n;
		int i;
		for (phase = 0; phase < 12; phase++) begin
			for (i = 0; i < REC_POOL; i++) begin
				rec_pool[i] = 16'($urandom_range(16'hFFFF));
			end
			for (i = 0; i < CLI_POOL; i++) begin
				cli_pool[i] = 8'($urandom_range(255));
			end
			rec_pool[0] = (phase % 3 == 0) ? 16'h0000 : (phase % 3 == 1) ? 16'hFFFF :
				rec_pool[0];
			cli_pool[0] = phase[0] ? 8'hFF : 8'h00;
			for (n = 0; n < 100; n++) begin
				send_request(random_request(phase % 2 == 0));
			end
		end
	endtask

	// a stretch with no idling on either side
	task automatic test_back_to_back();
		int n;
		send_idle_pct = 0;
		drain_idle_pct = 0;
		for (n = 0; n < 60; n++) begin
			send_request(random_request(n < 30));
		end
		send_idle_pct = 9;
		drain_idle_pct = 9;
	endtask

	// hold off results long enough that the block fills and stalls its input
	task automatic test_receiver_hold();
		int n;
		hold_left = 600;
		for (n = 0; n < 12; n++) begin
			send_request(random_request(1'b1));
		end
	endtask

	task automatic finish_run();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_outcomes.size() != 0) begin
			@(posedge clk);
		end
		repeat (2 * SCAN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	endtask

	initial begin
		for (int i = 0; i < HOLDERS; i++) begin
			lock_table[i].held = 1'b0;
			lock_table[i].rec = '0;
			lock_table[i].cli = '0;
			lock_table[i].exclusive = 1'b0;
		end
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_table_full();
		test_random_traffic();
		test_back_to_back();
		test_receiver_hold();
		finish_run();
	end

endmodule

// ===== files.f =====
rtl/rrwl_pkg.sv
rtl/rrwl_cell.sv
rtl/rrwl_ctrl.sv
rtl/record_reader_writer_lock_table.sv
tb/tb.sv
